// ===== rtl/core/tfdr_pkg.sv =====
`default_nettype none

package tfdr_pkg;

    // register indexes, decoded from paddr[2]
    localparam logic REG_CANVAS_COLS = 1'b0;
    localparam logic REG_CANVAS_ROWS = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] RST_CANVAS_COLS = 8'd80;
    localparam logic [6:0] RST_CANVAS_ROWS = 7'd25;

    localparam int CFG_COLS_W = 8;
    localparam int CFG_ROWS_W = 7;

    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic [6:0] rect_height;
        logic [7:0] rect_width;
        logic [5:0] rect_row;
        logic [6:0] rect_col;
        logic [6:0] canvas_rows;
        logic [7:0] canvas_cols;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tile_frame_dirty_rectangle_top.sv =====
// A frame's result is registered and offered once its last tile has left the compare stage.
// Throughput: one tile per cycle; the previous-frame RAM is read and rewritten at the
// same address in the accept cycle and compared in stage 1. The input stalls only
// while a frame's last tile waits in the compare stage behind an unaccepted result.
// Reset: canvas 80 x 25, frame restarts at (0,0), no previous frame held. The tile RAM
// is not cleared; the first frame writes every canvas entry before any entry is compared.
`default_nettype none

module tile_frame_dirty_rectangle_top
    import tfdr_pkg::*;
#(
    parameter int MAX_COLS  = 128,
    parameter int MAX_ROWS  = 64,
    parameter int TILE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] tile_char, [15:8] tile_attr
    input  wire logic [15:0]           s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] out_canvas_cols, [14:8] out_canvas_rows, [21:15] rect_col,
    // [27:22] rect_row, [35:28] rect_width, [42:36] rect_height, [47:43] zero
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic          last;
        logic          have_prev;
    } s1_ctl_t;

    // configuration
    logic [CFG_COLS_W-1:0] cols_cfg_reg;
    logic [CFG_ROWS_W-1:0] rows_cfg_reg;
    logic                  cfg_wr;
    logic [CW-1:0]         eff_cols;
    logic [RW-1:0]         eff_rows;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= RST_CANVAS_COLS;
            rows_cfg_reg <= RST_CANVAS_ROWS;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_CANVAS_COLS: cols_cfg_reg <= pwdata[CFG_COLS_W-1:0];
                REG_CANVAS_ROWS: rows_cfg_reg <= pwdata[CFG_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CANVAS_COLS: prdata = APB_DATA_W'(cols_cfg_reg);
            REG_CANVAS_ROWS: prdata = APB_DATA_W'(rows_cfg_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (cols_cfg_reg == '0)
            eff_cols = CW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            eff_cols = CW'(MAX_COLS);
        else
            eff_cols = CW'(cols_cfg_reg);

        if (rows_cfg_reg == '0)
            eff_rows = RW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            eff_rows = RW'(MAX_ROWS);
        else
            eff_rows = RW'(rows_cfg_reg);
    end

    // stage 0: raster position, RAM access
    logic [CW-1:0]        col_pos_reg, col_pos_next;
    logic [RW-1:0]        row_pos_reg, row_pos_next;
    logic                 hp_reg, hp_next;
    logic [CW-1:0]        col_cur;
    logic [RW-1:0]        row_cur;
    logic                 col_end, row_end;
    logic                 accept;
    logic [ADDR_W-1:0]    addr;
    logic [15:0]          tile_raw;
    logic [TILE_BITS-1:0] tile;
    logic [TILE_BITS-1:0] rd_data;
    logic                 advance;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign tile_raw = s_axis_tdata;
    assign tile     = TILE_BITS'(tile_raw);

    always_comb
    begin
        col_cur = (col_pos_reg >= eff_cols) ? '0 : col_pos_reg;
        row_cur = (row_pos_reg >= eff_rows) ? '0 : row_pos_reg;
        col_end = (col_cur == eff_cols - 1'b1);
        row_end = (row_cur == eff_rows - 1'b1);
        addr    = ADDR_W'(row_cur) * ADDR_W'(MAX_COLS) + ADDR_W'(col_cur);

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        hp_next      = hp_reg;
        if (cfg_wr)
        begin
            col_pos_next = '0;
            row_pos_next = '0;
            hp_next      = 1'b0;
        end
        else if (accept)
        begin
            if (!col_end)
            begin
                col_pos_next = col_cur + 1'b1;
                row_pos_next = row_cur;
            end
            else if (!row_end)
            begin
                col_pos_next = '0;
                row_pos_next = row_cur + 1'b1;
            end
            else
            begin
                col_pos_next = '0;
                row_pos_next = '0;
                hp_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            hp_reg      <= 1'b0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            hp_reg      <= hp_next;
        end
    end

    tfdr_ram #(
        .WIDTH (TILE_BITS),
        .DEPTH (DEPTH)
    ) u_prev_frame (
        .clk   (clk),
        .we    (accept),
        .waddr (addr),
        .wdata (tile),
        .re    (accept),
        .raddr (addr),
        .rdata (rd_data)
    );

    // stage 1: compare and bounding box
    logic                 s1_valid_reg, s1_valid_next;
    s1_ctl_t              s1_reg;
    logic [TILE_BITS-1:0] s1_tile_reg;
    logic [CW-1:0]        min_col_reg, min_col_next, end_col_reg, end_col_next;
    logic [RW-1:0]        min_row_reg, min_row_next, end_row_reg, end_row_next;
    logic [CW-1:0]        nmin_col, nend_col;
    logic [RW-1:0]        nmin_row, nend_row;
    logic                 changed;
    logic                 consume;
    result_t              res;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;

    assign advance       = !s1_valid_reg || !s1_reg.last || !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign consume       = s1_valid_reg && advance;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tile_reg <= tile;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_reg.col       <= col_cur;
                s1_reg.row       <= row_cur;
                s1_reg.last      <= col_end && row_end;
                s1_reg.have_prev <= hp_reg;
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        changed  = s1_reg.have_prev && (rd_data != s1_tile_reg);
        nmin_col = (changed && s1_reg.col < min_col_reg) ? s1_reg.col : min_col_reg;
        nmin_row = (changed && s1_reg.row < min_row_reg) ? s1_reg.row : min_row_reg;
        nend_col = (changed && s1_reg.col + 1'b1 > end_col_reg) ? s1_reg.col + 1'b1
                                                                 : end_col_reg;
        nend_row = (changed && s1_reg.row + 1'b1 > end_row_reg) ? s1_reg.row + 1'b1
                                                                 : end_row_reg;

        res.canvas_cols = 8'(eff_cols);
        res.canvas_rows = 7'(eff_rows);
        res.rect_col    = '0;
        res.rect_row    = '0;
        res.rect_width  = '0;
        res.rect_height = '0;
        if (!s1_reg.have_prev)
        begin
            res.rect_width  = 8'(eff_cols);
            res.rect_height = 7'(eff_rows);
        end
        else if (nmin_col < nend_col && nmin_row < nend_row)
        begin
            res.rect_col    = 7'(nmin_col);
            res.rect_row    = 6'(nmin_row);
            res.rect_width  = 8'(nend_col - nmin_col);
            res.rect_height = 7'(nend_row - nmin_row);
        end

        min_col_next = min_col_reg;
        min_row_next = min_row_reg;
        end_col_next = end_col_reg;
        end_row_next = end_row_reg;
        // empty box: min at the largest canvas, end at zero
        if (cfg_wr || (consume && s1_reg.last))
        begin
            min_col_next = CW'(MAX_COLS);
            min_row_next = RW'(MAX_ROWS);
            end_col_next = '0;
            end_row_next = '0;
        end
        else if (consume)
        begin
            min_col_next = nmin_col;
            min_row_next = nmin_row;
            end_col_next = nend_col;
            end_row_next = nend_row;
        end

        if (consume && s1_reg.last)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_col_reg <= CW'(MAX_COLS);
            min_row_reg <= RW'(MAX_ROWS);
            end_col_reg <= '0;
            end_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            min_col_reg <= min_col_next;
            min_row_reg <= min_row_next;
            end_col_reg <= end_col_next;
            end_row_reg <= end_row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && s1_reg.last)
        begin
            m_data_reg <= OUT_DATA_W'(res);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    result_t chk_res;
    assign chk_res = result_t'(m_data_reg[$bits(result_t)-1:0]);

    a_cfg_clears_prev: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !hp_reg)
        else $error("previous frame still valid after configuration write");

    a_s1_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_reg.col < eff_cols) && (s1_reg.row < eff_rows))
        else $error("stage 1 position outside canvas");

    a_rect_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (9'(chk_res.rect_col) + 9'(chk_res.rect_width)
                         <= 9'(chk_res.canvas_cols))
                     && (8'(chk_res.rect_row) + 8'(chk_res.rect_height)
                         <= 8'(chk_res.canvas_rows)))
        else $error("rectangle exceeds canvas");

    a_empty_rect_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && chk_res.rect_width == '0) |->
            (chk_res.rect_col == '0 && chk_res.rect_row == '0
             && chk_res.rect_height == '0))
        else $error("empty rectangle with nonzero fields");

endmodule

`default_nettype wire

// ===== rtl/core/tfdr_ram.sv =====
`default_nettype none

module tfdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
